// File: sv/assert_macros.svh
// assertion macros shared by the packer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication checked at every clock edge out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/bsp_pkg.sv
// shared types, constants and helpers of the bit stream packer
`default_nettype none

package bsp_pkg;

    localparam int INDEX_WIDTH  = 16;
    localparam int VALUE_WIDTH  = 64;
    localparam int CODE_WIDTH   = 3;
    localparam int BYTE_WIDTH   = 8;
    localparam int FILL_WIDTH   = 3;
    localparam int BITS_WIDTH   = 4;
    localparam int NBYTES_WIDTH = 4;

    // queue depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CODE_WIDTH-1:0] CODE_W1  = 3'd0;
    localparam logic [CODE_WIDTH-1:0] CODE_W8  = 3'd1;
    localparam logic [CODE_WIDTH-1:0] CODE_W16 = 3'd2;
    localparam logic [CODE_WIDTH-1:0] CODE_W32 = 3'd3;
    localparam logic [CODE_WIDTH-1:0] CODE_W64 = 3'd4;

    localparam logic [BITS_WIDTH-1:0] FULL_BITS = 4'd8;

    // classified request as held in the queue
    typedef struct packed {
        logic [VALUE_WIDTH-1:0]  value;
        logic [NBYTES_WIDTH-1:0] nbytes;
        logic                    one_bit;
        logic                    eos;
    } t_item;

    // whole bytes carried by a width code, zero for the one-bit and unused codes
    function automatic logic [NBYTES_WIDTH-1:0] code_nbytes(input logic [CODE_WIDTH-1:0] code);
        logic [NBYTES_WIDTH-1:0] n;
        case (code)
            CODE_W8:  n = 4'd1;
            CODE_W16: n = 4'd2;
            CODE_W32: n = 4'd4;
            CODE_W64: n = 4'd8;
            default:  n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: sv/bsp_front.sv
// front stage: registers incoming requests and classifies their width
`default_nettype none

module bsp_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [bsp_pkg::VALUE_WIDTH-1:0] i_value,
    input  wire logic [bsp_pkg::CODE_WIDTH-1:0]  i_width_code,
    input  wire logic                          i_end_of_stream,
    output logic                               o_push,
    output bsp_pkg::t_item                     o_item,
    input  wire logic                          i_push_ready
);
    import bsp_pkg::*;

    logic   r_valid;
    t_item  r_item;
    t_item  n_item;
    logic   take;

    assign o_in_ready = !r_valid || i_push_ready;
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_item.value   = i_value;
        n_item.nbytes  = code_nbytes(i_width_code);
        n_item.one_bit = (i_width_code == CODE_W1);
        n_item.eos     = i_end_of_stream;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_push = r_valid;
    assign o_item = r_item;

endmodule

`default_nettype wire

// File: sv/bsp_queue.sv
// short request queue between front and back
`default_nettype none

module bsp_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire bsp_pkg::t_item i_item,
    output logic           o_push_ready,
    output logic           o_head_valid,
    output bsp_pkg::t_item o_head,
    input  wire logic      i_pop
);
    import bsp_pkg::*;

    `include "assert_macros.svh"

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_push_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue over depth")
    `ASSERT_IMPLIES(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")

endmodule

`default_nettype wire

// File: sv/bsp_back.sv
// back stage: merges bytes into the bit stream and drives the output register
`default_nettype none

module bsp_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_head_valid,
    input  wire bsp_pkg::t_item                  i_head,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [bsp_pkg::BYTE_WIDTH-1:0]       o_out_byte,
    output logic [bsp_pkg::INDEX_WIDTH-1:0]      o_byte_index,
    output logic [bsp_pkg::BITS_WIDTH-1:0]       o_valid_bits,
    output logic                                 o_last
);
    import bsp_pkg::*;

    `include "assert_macros.svh"

    logic [NBYTES_WIDTH-1:0] r_step;
    logic [BYTE_WIDTH-1:0]   r_partial;
    logic [FILL_WIDTH-1:0]   r_fill;
    logic [INDEX_WIDTH-1:0]  r_pos;

    logic                    r_out_valid;
    logic [BYTE_WIDTH-1:0]   r_out_byte;
    logic [INDEX_WIDTH-1:0]  r_out_index;
    logic [BITS_WIDTH-1:0]   r_out_bits;
    logic                    r_out_last;

    logic [NBYTES_WIDTH-1:0] n_step;
    logic [BYTE_WIDTH-1:0]   n_partial;
    logic [FILL_WIDTH-1:0]   n_fill;
    logic [INDEX_WIDTH-1:0]  n_pos;

    logic                    out_free;
    logic                    advance;
    logic                    emit;
    logic [BYTE_WIDTH-1:0]   emit_byte;
    logic [BITS_WIDTH-1:0]   emit_bits;
    logic                    emit_last;
    logic                    pop;

    logic [BYTE_WIDTH-1:0]   src_byte;
    logic [2*BYTE_WIDTH-1:0] merged;
    logic [BYTE_WIDTH-1:0]   bit_partial;
    logic [BITS_WIDTH-1:0]   fill_p1;
    logic                    has_flush;
    logic                    final_byte;
    logic [BYTE_WIDTH-1:0]   fill_mask;

    assign out_free = !r_out_valid || i_out_ready;
    assign advance  = i_head_valid && out_free;

    assign src_byte    = i_head.value[{r_step[2:0], 3'b000} +: BYTE_WIDTH];
    assign merged      = {8'd0, r_partial} | ({8'd0, src_byte} << r_fill);
    assign bit_partial = r_partial | ({7'd0, i_head.value[0]} << r_fill);
    assign fill_p1     = {1'b0, r_fill} + 4'd1;
    assign has_flush   = i_head.eos && (r_fill != '0);
    assign final_byte  = (r_step == (i_head.nbytes - 4'd1));
    assign fill_mask   = ~(8'hff << r_fill);

    always_comb begin
        n_step    = r_step;
        n_partial = r_partial;
        n_fill    = r_fill;
        n_pos     = r_pos;
        emit      = 1'b0;
        emit_byte = r_partial;
        emit_bits = FULL_BITS;
        emit_last = 1'b1;
        pop       = 1'b0;
        if (i_head.one_bit) begin
            // single bit, a byte leaves when it fills or on flush
            pop       = 1'b1;
            emit      = (r_fill == 3'd7) || i_head.eos;
            emit_byte = bit_partial;
            emit_bits = (r_fill == 3'd7) ? FULL_BITS : fill_p1;
            n_partial = bit_partial;
            n_fill    = fill_p1[FILL_WIDTH-1:0];
            if (r_fill == 3'd7) begin
                n_partial = '0;
                n_pos     = r_pos + 1'b1;
            end
        end else if (r_step < i_head.nbytes) begin
            // one byte of a multi-byte value, high bits carry over
            emit      = 1'b1;
            emit_byte = merged[BYTE_WIDTH-1:0];
            emit_last = final_byte && !has_flush;
            n_partial = merged[2*BYTE_WIDTH-1:BYTE_WIDTH];
            n_pos     = r_pos + 1'b1;
            if (final_byte && !has_flush) begin
                pop    = 1'b1;
                n_step = '0;
            end else begin
                n_step = r_step + 4'd1;
            end
        end else begin
            // flush of the partial byte, or an item with nothing to send
            pop       = 1'b1;
            n_step    = '0;
            emit      = has_flush;
            emit_byte = r_partial & fill_mask;
            emit_bits = {1'b0, r_fill};
        end
        if (pop && i_head.eos) begin
            n_partial = '0;
            n_fill    = '0;
            n_pos     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_partial   <= '0;
            r_fill      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_step    <= n_step;
                r_partial <= n_partial;
                r_fill    <= n_fill;
                r_pos     <= n_pos;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_byte  <= emit_byte;
            r_out_index <= r_pos;
            r_out_bits  <= emit_bits;
            r_out_last  <= emit_last;
        end
    end

    assign o_pop        = advance && pop;
    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_index = r_out_index;
    assign o_valid_bits = r_out_bits;
    assign o_last       = r_out_last;

    `ASSERT_ALWAYS(a_partial_clean, i_clk, i_rst_n, (r_partial >> r_fill) == 8'd0, "stale bits above fill")
    `ASSERT_ALWAYS(a_step_bound, i_clk, i_rst_n, r_step <= 4'd8, "byte step out of range")
    `ASSERT_IMPLIES(a_bits_nonzero, i_clk, i_rst_n, r_out_valid, r_out_bits != 4'd0, "empty byte sent")

endmodule

`default_nettype wire

// File: sv/bit_stream_packer_unit.sv
// top level of the lsb-first bit stream packer
//
// input channel: i_in_valid / o_in_ready carry one request of i_value,
//   i_width_code (0 = 1 bit, 1 = 8, 2 = 16, 3 = 32, 4 = 64 bits, others append
//   nothing) and i_end_of_stream, which flushes a partial byte afterwards
// output channel: o_out_valid / i_out_ready carry one stream byte a cycle with
//   its index, valid bit count (8, or 1..7 for a flushed partial byte) and
//   o_last on the final byte that a request produces
// path: a request passes the input register and the queue to the byte merger,
//   whose output register shows its bytes
// throughput: the byte merger sends one byte a cycle while the receiver takes
//   them; a request yields 1, 2, 4 or 8 bytes plus one for a flush, and a
//   request that yields nothing still passes through the byte merger
// reset: partial byte, fill count and byte index return to zero, the queue
//   empties and no byte is shown
// a stalled receiver holds the output register; the queue and input register
//   keep taking requests until they fill, then o_in_ready drops
`default_nettype none

module bit_stream_packer_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [bsp_pkg::VALUE_WIDTH-1:0]   i_value,
    input  wire logic [bsp_pkg::CODE_WIDTH-1:0]    i_width_code,
    input  wire logic                              i_end_of_stream,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [bsp_pkg::BYTE_WIDTH-1:0]         o_out_byte,
    output logic [bsp_pkg::INDEX_WIDTH-1:0]        o_byte_index,
    output logic [bsp_pkg::BITS_WIDTH-1:0]         o_valid_bits,
    output logic                                   o_last
);
    import bsp_pkg::*;

    // front to queue
    logic  push;
    t_item push_item;
    logic  push_ready;

    // queue to back
    logic  head_valid;
    t_item head;
    logic  pop;

    // input register and width classification
    bsp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_value         (i_value),
        .i_width_code    (i_width_code),
        .i_end_of_stream (i_end_of_stream),
        .o_push          (push),
        .o_item          (push_item),
        .i_push_ready    (push_ready)
    );

    // decouples request intake from byte output
    bsp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (push_item),
        .o_push_ready (push_ready),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // byte merger, stream state and output register
    bsp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_index (o_byte_index),
        .o_valid_bits (o_valid_bits),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// File: verif/bit_stream_packer_checker.sv
// checker of the bit stream packer: predicts the stream bytes and compares them
module bit_stream_packer_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [bsp_pkg::VALUE_WIDTH-1:0]     i_value,
    input  logic [bsp_pkg::CODE_WIDTH-1:0]      i_width_code,
    input  logic                                i_end_of_stream,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [bsp_pkg::BYTE_WIDTH-1:0]      i_out_byte,
    input  logic [bsp_pkg::INDEX_WIDTH-1:0]     i_byte_index,
    input  logic [bsp_pkg::BITS_WIDTH-1:0]      i_valid_bits,
    input  logic                                i_last,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    import bsp_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0]  data;
        logic [INDEX_WIDTH-1:0] index;
        logic [BITS_WIDTH-1:0]  bits;
        logic                   last;
    } t_stream_byte;

    t_stream_byte           expected_bytes[$];
    logic [BYTE_WIDTH-1:0]  partial_byte;
    int                     fill_count;
    logic [INDEX_WIDTH-1:0] stream_position;
    int                     mismatches;

    initial begin
        mismatches = 0;
    end

    // one completed byte of the stream
    task automatic push_full_byte(input logic [BYTE_WIDTH-1:0] data);
        expected_bytes.push_back('{data, stream_position, FULL_BITS, 1'b0});
        stream_position = stream_position + 1'b1;
    endtask

    task automatic pack_request(input logic [VALUE_WIDTH-1:0] value,
                                input logic [CODE_WIDTH-1:0]  code,
                                input logic                   eos);
        logic [2*BYTE_WIDTH-1:0] merged;
        logic [BYTE_WIDTH-1:0]   mask;
        int                      nbytes;
        int                      before_count;
        before_count = expected_bytes.size();
        nbytes = 0;
        case (code)
            CODE_W1: begin
                partial_byte = partial_byte | ({7'b0, value[0]} << fill_count);
                fill_count++;
                if (fill_count == BYTE_WIDTH) begin
                    push_full_byte(partial_byte);
                    partial_byte = '0;
                    fill_count   = 0;
                end
            end
            CODE_W8:  nbytes = 1;
            CODE_W16: nbytes = 2;
            CODE_W32: nbytes = 4;
            CODE_W64: nbytes = 8;
            default:  nbytes = 0;
        endcase
        // unaligned bytes split across the current and the next partial byte
        for (int i = 0; i < nbytes; i++) begin
            merged = {8'h00, partial_byte} | ({8'h00, value[8*i +: 8]} << fill_count);
            push_full_byte(merged[7:0]);
            partial_byte = merged[15:8];
        end
        if (eos) begin
            if (fill_count != 0) begin
                mask = (8'h01 << fill_count) - 8'h01;
                expected_bytes.push_back('{partial_byte & mask, stream_position,
                                           BITS_WIDTH'(fill_count), 1'b0});
            end
            partial_byte    = '0;
            fill_count      = 0;
            stream_position = '0;
        end
        if (expected_bytes.size() > before_count)
            expected_bytes[expected_bytes.size()-1].last = 1'b1;
    endtask

    task automatic compare_byte();
        t_stream_byte want;
        if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("unexpected byte %02h index %0d bits %0d last %0b",
                         i_out_byte, i_byte_index, i_valid_bits, i_last);
        end else begin
            want = expected_bytes.pop_front();
            if (i_out_byte !== want.data || i_byte_index !== want.index ||
                i_valid_bits !== want.bits || i_last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("byte mismatch: exp %02h/%0d/%0d/%0b got %02h/%0d/%0d/%0b",
                             want.data, want.index, want.bits, want.last,
                             i_out_byte, i_byte_index, i_valid_bits, i_last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_bytes.delete();
            partial_byte    = '0;
            fill_count      = 0;
            stream_position = '0;
        end else begin
            if (i_in_valid && i_in_ready)
                pack_request(i_value, i_width_code, i_end_of_stream);
            if (i_out_valid && i_out_ready)
                compare_byte();
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: verif/bit_stream_packer_unit_test.sv
// testbench top of the bit stream packer: stimulus, receiver stalls and verdict
module bit_stream_packer_unit_test;

    import bsp_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 8;      // settling margin after the output drains
    localparam int STALL_CYCLES   = 300;    // long enough to fill the queue and input register
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int PHASE_REQUESTS = 75;

    // width codes that append nothing
    localparam logic [CODE_WIDTH-1:0] CODE_SPARE5 = 3'd5;
    localparam logic [CODE_WIDTH-1:0] CODE_SPARE6 = 3'd6;
    localparam logic [CODE_WIDTH-1:0] CODE_SPARE7 = 3'd7;

    localparam logic [VALUE_WIDTH-1:0] ALL_ONES = '1;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [VALUE_WIDTH-1:0]  i_value;
    logic [CODE_WIDTH-1:0]   i_width_code;
    logic                    i_end_of_stream;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [BYTE_WIDTH-1:0]   o_out_byte;
    logic [INDEX_WIDTH-1:0]  o_byte_index;
    logic [BITS_WIDTH-1:0]   o_valid_bits;
    logic                    o_last;

    int fail_count;
    int pending_bytes;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_asks;
    int stall_taken;
    int stall_left;

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    bit_stream_packer_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_value         (i_value),
        .i_width_code    (i_width_code),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_index    (o_byte_index),
        .o_valid_bits    (o_valid_bits),
        .o_last          (o_last)
    );

    bit_stream_packer_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_value         (i_value),
        .i_width_code    (i_width_code),
        .i_end_of_stream (i_end_of_stream),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out_byte      (o_out_byte),
        .i_byte_index    (o_byte_index),
        .i_valid_bits    (o_valid_bits),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending_bytes)
    );

    // receiver: random back-pressure, or a counted hold-off when one is asked for
    initial begin
        stall_taken = 0;
        stall_left  = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_asks != stall_taken) begin
                stall_taken = stall_asks;
                stall_left  = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left = stall_left - 1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // offer one request, with random idle cycles first, and wait for its acceptance
    task automatic send_request(input logic [VALUE_WIDTH-1:0] value,
                                input logic [CODE_WIDTH-1:0]  code,
                                input logic                   eos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_value         <= value;
        i_width_code    <= code;
        i_end_of_stream <= eos;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop offering until every predicted byte has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_bytes != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random streams: mostly well-formed runs of writes closed by end of stream,
    // with the odd mid-stream flush, unused width code or stream left open
    task automatic run_streams(input int request_goal);
        int                     counted;
        int                     stream_len;
        int                     pick;
        logic [CODE_WIDTH-1:0]  code;
        logic                   eos;
        logic [VALUE_WIDTH-1:0] value;
        counted = 0;
        while (counted < request_goal) begin
            stream_len = $urandom_range(1, 12);
            for (int j = 0; j < stream_len && counted < request_goal; j++) begin
                pick = $urandom_range(99);
                if (pick < 30)
                    code = CODE_W1;
                else if (pick < 45)
                    code = CODE_W8;
                else if (pick < 60)
                    code = CODE_W16;
                else if (pick < 75)
                    code = CODE_W32;
                else if (pick < 95)
                    code = CODE_W64;
                else
                    code = CODE_SPARE5 + CODE_WIDTH'($urandom_range(2));
                if (j == stream_len - 1)
                    eos = ($urandom_range(9) != 0);
                else
                    eos = ($urandom_range(29) == 0);
                pick = $urandom_range(9);
                if (pick == 0)
                    value = '0;
                else if (pick == 1)
                    value = ALL_ONES;
                else
                    value = {$urandom, $urandom};
                send_request(value, code, eos);
                // an unused code without a flush changes nothing
                if (code <= CODE_W64 || eos)
                    counted++;
            end
        end
    endtask

    // hard limit on the run
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_value         <= '0;
        i_width_code    <= CODE_W1;
        i_end_of_stream <= 1'b0;
        stall_asks      = 0;
        send_idle_pct   = 24;
        recv_idle_pct   = 59;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: flush of an empty stream, aligned writes of every multi-byte width
        send_request('0, CODE_SPARE5, 1'b1);
        send_request(64'hff, CODE_W8, 1'b0);
        send_request(64'h8001, CODE_W16, 1'b0);
        send_request(64'hdeadbeef, CODE_W32, 1'b0);
        send_request(ALL_ONES, CODE_W64, 1'b0);
        send_request('0, CODE_W64, 1'b0);
        // three single bits, then unaligned multi-byte writes
        send_request(64'h1, CODE_W1, 1'b0);
        send_request(64'h0, CODE_W1, 1'b0);
        send_request(64'h1, CODE_W1, 1'b0);
        send_request(64'ha5c3, CODE_W16, 1'b0);
        send_request(64'h0123456789abcdef, CODE_W64, 1'b0);
        // high bits beyond the width are ignored
        send_request(64'hffffffffffffff00, CODE_W8, 1'b0);
        // unused code still flushes the partial byte
        send_request(ALL_ONES, CODE_SPARE7, 1'b1);
        // single bits that complete a byte together with end of stream
        repeat (7) send_request(ALL_ONES, CODE_W1, 1'b0);
        send_request(64'h1, CODE_W1, 1'b1);
        send_request(64'h1, CODE_W1, 1'b0);
        send_request('0, CODE_SPARE6, 1'b1);
        // unaligned widest write with a flush: nine bytes from one request
        send_request(64'h0, CODE_W1, 1'b0);
        send_request(ALL_ONES, CODE_W64, 1'b1);
        wait_drained();

        // sender idles less than the receiver
        run_streams(PHASE_REQUESTS);
        wait_drained();

        // the other way round
        send_idle_pct = 59;
        recv_idle_pct = 24;
        run_streams(PHASE_REQUESTS);
        wait_drained();

        // no idling; a long receiver hold-off fills the block and stalls its input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_asks    = stall_asks + 1;
        run_streams(PHASE_REQUESTS);
        wait_drained();

        if (fail_count == 0 && pending_bytes == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
